// File: hw/rtl/data_cache_lru_writeback_macros.svh
// Assertion macros shared by the data cache RTL.
// Included by modules that carry concurrent checks.
`ifndef DATA_CACHE_LRU_WRITEBACK_MACROS_SVH
`define DATA_CACHE_LRU_WRITEBACK_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define DC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define DC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/dclru_pkg.sv
// Package for the data cache: action codes, FSM codes and shared types.
// No dependencies.
package dclru_pkg;
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_FILL   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] address;
        logic [3:0]  size;
        logic [63:0] store_value;
        logic [255:0] fill_line;
    } t_req;

    typedef struct packed {
        logic         hit;
        logic         misaligned;
        logic [63:0]  load_data;
        logic         wb_valid;
        logic [63:0]  wb_address;
        logic [255:0] wb_line;
    } t_rsp;
endpackage

// File: hw/rtl/dclru_store.sv
// Per-set state memories of the cache: one holds tag, rank and valid of all ways,
// the other holds the line data. Standalone; used by data_cache_lru_writeback.
module dclru_store #(
    parameter int SETS  = 256,
    parameter int WAYS  = 8,
    parameter int LINEB = 32,
    parameter int TAGW  = 51
) (
    input  logic                          i_clk,
    input  logic [$clog2(SETS)-1:0]       i_rd_set,
    output logic [WAYS-1:0][TAGW-1:0]     o_rd_tag,
    output logic [WAYS-1:0][LINEB*8-1:0]  o_rd_data,
    output logic [WAYS-1:0][$clog2(WAYS)-1:0] o_rd_rank,
    output logic [WAYS-1:0]               o_rd_valid,
    input  logic                          i_we,
    input  logic [$clog2(SETS)-1:0]       i_wr_set,
    input  logic [WAYS-1:0][TAGW-1:0]     i_wr_tag,
    input  logic [WAYS-1:0][LINEB*8-1:0]  i_wr_data,
    input  logic [WAYS-1:0][$clog2(WAYS)-1:0] i_wr_rank,
    input  logic [WAYS-1:0]               i_wr_valid
);
    localparam int RW = $clog2(WAYS);
    localparam int MW = TAGW + RW + 1;

    logic [WAYS-1:0][MW-1:0]      r_meta_mem [SETS];
    logic [WAYS-1:0][LINEB*8-1:0] r_data_mem [SETS];
    logic [WAYS-1:0][MW-1:0]      r_meta_rd;
    logic [WAYS-1:0][MW-1:0]      wr_meta;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            wr_meta[w]    = {i_wr_tag[w], i_wr_rank[w], i_wr_valid[w]};
            o_rd_tag[w]   = r_meta_rd[w][MW-1 -: TAGW];
            o_rd_rank[w]  = r_meta_rd[w][RW:1];
            o_rd_valid[w] = r_meta_rd[w][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_meta_mem[i_wr_set] <= wr_meta;
            r_data_mem[i_wr_set] <= i_wr_data;
        end
        r_meta_rd <= r_meta_mem[i_rd_set];
        o_rd_data <= r_data_mem[i_rd_set];
    end
endmodule

// File: hw/rtl/data_cache_lru_writeback.sv
// Top level of the data cache: stream ports, request FSM, lookup and update.
// Depends on dclru_pkg, dclru_store and the assertion macro header.
//
// Channel  | Dir | Contents
// s_axis   | in  | tuser: action; tdata: address, access_size, store_value, fill words
// m_axis   | out | tuser: hit, misaligned, wb valid; tdata: load_data, wb addr, wb words
//
// Each request passes through the states accept, set memory read, update and result in order.
// The result is valid once the read and update states follow acceptance; one request is in flight.
// Reset is synchronous and active low; it clears per-set valid flags at once.
// A stalled result holds the block; the next request is taken after delivery.
`include "data_cache_lru_writeback_macros.svh"
module data_cache_lru_writeback #(
    parameter int SET_COUNT       = 256,
    parameter int WAY_COUNT       = 8,
    parameter int LINE_BYTE_COUNT = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    // address[63:0], access_size[67:64], store_value[131:68],
    // fill_word_0..3[387:132], zero pad to 392 bits
    input  logic [391:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0], misaligned[1], writeback_valid[2]
    output logic [2:0]   m_axis_tuser,
    // load_data[63:0], writeback_address[127:64], writeback_word_0..3[383:128]
    output logic [383:0] m_axis_tdata
);
    localparam int SW   = $clog2(SET_COUNT);
    localparam int WW   = $clog2(WAY_COUNT);
    localparam int OW   = $clog2(LINE_BYTE_COUNT);
    localparam int TAGW = 64 - SW - OW;
    localparam int LW   = LINE_BYTE_COUNT * 8;

    logic [1:0]  r_state, n_state;
    dclru_pkg::t_req r_req;
    dclru_pkg::t_rsp r_rsp, n_rsp;

    logic [WAY_COUNT-1:0][TAGW-1:0] rd_tag, wr_tag;
    logic [WAY_COUNT-1:0][LW-1:0]   rd_data, wr_data;
    logic [WAY_COUNT-1:0][WW-1:0]   rd_rank, wr_rank, m_rank;
    logic [WAY_COUNT-1:0]           rd_valid, wr_valid, m_valid;
    logic                           we;
    logic [SET_COUNT-1:0]           r_init;
    logic                           r_rd_init;

    logic [SW-1:0]   req_set;
    logic [TAGW-1:0] req_tag;
    logic [OW-1:0]   req_off;
    assign req_off = r_req.address[OW-1:0];
    assign req_set = r_req.address[OW +: SW];
    assign req_tag = r_req.address[63 -: TAGW];

    dclru_store #(
        .SETS(SET_COUNT), .WAYS(WAY_COUNT), .LINEB(LINE_BYTE_COUNT), .TAGW(TAGW)
    ) u_store (
        .i_clk(i_clk), .i_rd_set(req_set),
        .o_rd_tag(rd_tag), .o_rd_data(rd_data), .o_rd_rank(rd_rank),
        .o_rd_valid(rd_valid), .i_we(we), .i_wr_set(req_set),
        .i_wr_tag(wr_tag), .i_wr_data(wr_data), .i_wr_rank(wr_rank),
        .i_wr_valid(wr_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            r_rd_init <= r_init[req_set];
            if (we) begin
                r_init[req_set] <= 1'b1;
            end
        end
    end
    assign m_rank  = r_rd_init ? rd_rank : '0;
    assign m_valid = r_rd_init ? rd_valid : '0;

    logic [4:0]  size_sat;
    logic        misal, hit, any_inv, is_acc;
    logic [WW-1:0] hway, inv_way, lru_way, vic;
    logic [LW-1:0] line, upd_line, fill_line;
    logic [7:0][OW-1:0] byte_idx;
    logic [63:0]   ld;
    logic [WW-1:0] limit;

    always_comb begin
        size_sat = (r_req.size > 4'd8) ? 5'd8 : {1'b0, r_req.size};
        misal = (32'(req_off) + 32'(size_sat)) > 32'(LINE_BYTE_COUNT);
        is_acc = (r_req.action == dclru_pkg::ACT_LOAD) ||
                 (r_req.action == dclru_pkg::ACT_STORE);
        hit = 1'b0; hway = '0;
        for (int w = WAY_COUNT-1; w >= 0; w--) begin
            if (m_valid[w] && rd_tag[w] == req_tag) begin
                hit = 1'b1; hway = WW'(w);
            end
        end
        any_inv = 1'b0; inv_way = '0;
        for (int w = WAY_COUNT-1; w >= 0; w--) begin
            if (!m_valid[w]) begin
                any_inv = 1'b1; inv_way = WW'(w);
            end
        end
        lru_way = '0;
        for (int w = 1; w < WAY_COUNT; w++) begin
            if (m_rank[w] > m_rank[lru_way]) lru_way = WW'(w);
        end
        vic = any_inv ? inv_way : lru_way;
        line = rd_data[hway];
        ld = '0;
        upd_line = line;
        for (int j = 0; j < 8; j++) begin
            byte_idx[j] = req_off + OW'(j);
            if (5'(j) < size_sat) begin
                ld[8*j +: 8] = line[8*byte_idx[j] +: 8];
                upd_line[8*byte_idx[j] +: 8] = r_req.store_value[8*j +: 8];
            end
        end
        fill_line = '0;
        for (int j = 0; j < LINE_BYTE_COUNT; j++) begin
            if (j < 32) fill_line[8*j +: 8] = r_req.fill_line[(8*j) % 256 +: 8];
        end

        wr_tag = rd_tag; wr_data = rd_data; wr_valid = m_valid; wr_rank = m_rank;
        n_rsp = '0;
        we = 1'b0;
        limit = '0;
        if (r_state == dclru_pkg::ST_EXEC) begin
            if (is_acc) begin
                if (misal) begin
                    n_rsp.misaligned = 1'b1;
                end else if (hit) begin
                    n_rsp.hit = 1'b1;
                    we = 1'b1;
                    if (r_req.action == dclru_pkg::ACT_LOAD) n_rsp.load_data = ld;
                    else wr_data[hway] = upd_line;
                    for (int v = 0; v < WAY_COUNT; v++) begin
                        if (WW'(v) != hway && m_valid[v] && m_rank[v] < m_rank[hway])
                            wr_rank[v] = m_rank[v] + 1'b1;
                    end
                    wr_rank[hway] = '0;
                end
            end else if (r_req.action == dclru_pkg::ACT_FILL) begin
                we = 1'b1;
                if (!any_inv) begin
                    n_rsp.wb_valid   = 1'b1;
                    n_rsp.wb_address = {rd_tag[vic], req_set, {OW{1'b0}}};
                    for (int j = 0; j < 32; j++) begin
                        if (j < LINE_BYTE_COUNT)
                            n_rsp.wb_line[8*j +: 8] = rd_data[vic][(8*j) % LW +: 8];
                    end
                    limit = m_rank[vic];
                end
                for (int v = 0; v < WAY_COUNT; v++) begin
                    if (WW'(v) != vic && m_valid[v] && (any_inv || m_rank[v] < limit))
                        wr_rank[v] = m_rank[v] + 1'b1;
                end
                wr_rank[vic]  = '0;
                wr_valid[vic] = 1'b1;
                wr_tag[vic]   = req_tag;
                wr_data[vic]  = fill_line;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dclru_pkg::ST_IDLE: if (s_axis_tvalid) n_state = dclru_pkg::ST_READ;
            dclru_pkg::ST_READ: n_state = dclru_pkg::ST_EXEC;
            dclru_pkg::ST_EXEC: n_state = dclru_pkg::ST_OUT;
            dclru_pkg::ST_OUT:  if (m_axis_tready) n_state = dclru_pkg::ST_IDLE;
            default:            n_state = dclru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dclru_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_req.action      <= s_axis_tuser;
            r_req.address     <= s_axis_tdata[63:0];
            r_req.size        <= s_axis_tdata[67:64];
            r_req.store_value <= s_axis_tdata[131:68];
            r_req.fill_line   <= s_axis_tdata[387:132];
        end
        if (r_state == dclru_pkg::ST_EXEC) begin
            r_rsp <= n_rsp;
        end
    end

    assign s_axis_tready = (r_state == dclru_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == dclru_pkg::ST_OUT);
    assign m_axis_tuser  = {r_rsp.wb_valid, r_rsp.misaligned, r_rsp.hit};
    assign m_axis_tdata  = {r_rsp.wb_line, r_rsp.wb_address, r_rsp.load_data};

    logic in_fire, out_fire, st_read, rsp_bad;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign st_read  = (r_state == dclru_pkg::ST_READ);
    assign rsp_bad  = r_rsp.hit && (r_rsp.misaligned || r_rsp.wb_valid);

    `DC_ASSERT_IMP(a_one_side, i_clk, i_rst_n, 1'b1, !(s_axis_tready && m_axis_tvalid))
    `DC_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, in_fire, st_read)
    `DC_ASSERT_IMP(a_rsp_excl, i_clk, i_rst_n, m_axis_tvalid, !rsp_bad)
    `DC_ASSERT_NEXT(a_one_rsp, i_clk, i_rst_n, out_fire, !m_axis_tvalid)
endmodule
